>>> rtl/core/bsfd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bsfd_pkg
// Shared constants, types and helpers for the byte-stuffed frame decoder.
// ----------------------------------------------------------------------------
package bsfd_pkg;

  // default payload length in bytes
  localparam int PAYLOAD_BYTES_DEF = 40;

  // field widths fixed by the result format
  localparam int BYTE_W  = 8;
  localparam int WORD_W  = 32;
  localparam int IDX_W   = 4;
  localparam int STAT_W  = 2;

  // framing bytes
  localparam logic [BYTE_W-1:0] FLAG_BYTE = 8'h7E;
  localparam logic [BYTE_W-1:0] ESC_BYTE  = 8'h7D;

  // escape followers and the bytes they stand for
  localparam logic [BYTE_W-1:0] ESC_FLAG_CODE = 8'h5E;
  localparam logic [BYTE_W-1:0] ESC_ESC_CODE  = 8'h5D;
  localparam logic [BYTE_W-1:0] ESC_XON_CODE  = 8'h31;
  localparam logic [BYTE_W-1:0] ESC_XOFF_CODE = 8'h33;
  localparam logic [BYTE_W-1:0] XON_BYTE      = 8'h11;
  localparam logic [BYTE_W-1:0] XOFF_BYTE     = 8'h13;

  // frame status codes
  localparam logic [STAT_W-1:0] ST_OK        = 2'd0;
  localparam logic [STAT_W-1:0] ST_DEV_STATE = 2'd1;
  localparam logic [STAT_W-1:0] ST_BAD_END   = 2'd2;
  localparam logic [STAT_W-1:0] ST_BAD_SUM   = 2'd3;

  // commands from controller to datapath
  typedef struct packed {
    logic              start;    // frame opened, clear running state
    logic              hdr;      // header byte accepted
    logic              pay;      // payload byte accepted
    logic              chk;      // checksum byte accepted
    logic              wclr;     // clear stream word index
    logic              emit_st;  // load a status result
    logic [STAT_W-1:0] st_code;
    logic              rd;       // read stored word at stream index
    logic              ld;       // load read word into output register
  } dec_cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic is_flag;    // current byte is the flag
    logic hdr_done;   // current header byte is the last header byte
    logic hdr_fault;  // state byte was nonzero
    logic pay_done;   // current payload byte completes the payload
    logic sum_fault;  // checksum byte was wrong
    logic word_last;  // stream index at final word
    logic out_free;   // output register free or draining this cycle
  } dec_sts_t;

  // value of an escaped byte from its follower
  function automatic logic [BYTE_W-1:0] unstuff(input logic [BYTE_W-1:0] b);
    logic [BYTE_W-1:0] v;
    case (b)
      ESC_FLAG_CODE: v = FLAG_BYTE;
      ESC_ESC_CODE:  v = ESC_BYTE;
      ESC_XON_CODE:  v = XON_BYTE;
      ESC_XOFF_CODE: v = XOFF_BYTE;
      default:       v = ESC_BYTE;
    endcase
    return v;
  endfunction

endpackage

>>> rtl/core/bsfd_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bsfd_datapath
// Counters, running sum, unstuffing, payload word store and output register.
// ----------------------------------------------------------------------------
module bsfd_datapath import bsfd_pkg::*; #(
  parameter int PAYLOAD_BYTES = PAYLOAD_BYTES_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic [BYTE_W-1:0] rx_byte,
  input  dec_cmd_t          cmd,
  output dec_sts_t          sts,
  input  logic              out_ready,
  output logic              out_valid,
  output logic [WORD_W-1:0] word_value,
  output logic [IDX_W-1:0]  word_index,
  output logic [STAT_W-1:0] frame_status,
  output logic              last
);

  localparam int CNT_W   = $clog2(PAYLOAD_BYTES);
  localparam int NUM_WORDS = PAYLOAD_BYTES / 4;
  localparam int WORD_AW = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;

  logic [CNT_W-1:0]   byte_count;
  logic [BYTE_W-1:0]  running_sum;
  logic               escape_pending;
  logic               state_fault;
  logic               sum_fault;
  logic [23:0]        word_shift;
  logic [WORD_AW-1:0] widx;
  logic [WORD_W-1:0]  rd_data;
  logic [WORD_W-1:0]  word_store [NUM_WORDS];

  logic               pay_take;
  logic [BYTE_W-1:0]  pay_val;
  logic               word_wr;
  logic [WORD_AW-1:0] wr_addr;

  // unstuffing of the current payload byte
  always_comb begin
    pay_take = escape_pending || (rx_byte != ESC_BYTE);
    pay_val  = escape_pending ? unstuff(rx_byte) : rx_byte;
    word_wr  = cmd.pay && pay_take && (byte_count[1:0] == 2'd3);
    wr_addr  = WORD_AW'(byte_count >> 2);
  end

  // status towards the controller
  always_comb begin
    sts.is_flag   = (rx_byte == FLAG_BYTE);
    sts.hdr_done  = (byte_count == CNT_W'(3));
    sts.hdr_fault = state_fault;
    sts.pay_done  = pay_take && (byte_count >= CNT_W'(PAYLOAD_BYTES - 1));
    sts.sum_fault = sum_fault;
    sts.word_last = (widx == WORD_AW'(NUM_WORDS - 1));
    sts.out_free  = !out_valid || out_ready;
  end

  // frame state: count, sum, escape and fault flags
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_count     <= '0;
      running_sum    <= '0;
      escape_pending <= 1'b0;
      state_fault    <= 1'b0;
      sum_fault      <= 1'b0;
    end else if (cmd.start) begin
      byte_count     <= '0;
      running_sum    <= '0;
      escape_pending <= 1'b0;
      state_fault    <= 1'b0;
      sum_fault      <= 1'b0;
    end else if (cmd.hdr) begin
      running_sum <= running_sum + rx_byte;
      if (byte_count == CNT_W'(2) && rx_byte != '0) begin
        state_fault <= 1'b1;
      end
      byte_count <= sts.hdr_done ? '0 : byte_count + 1'b1;
    end else if (cmd.pay) begin
      if (escape_pending) begin
        escape_pending <= 1'b0;
      end else if (rx_byte == ESC_BYTE) begin
        escape_pending <= 1'b1;
      end
      if (pay_take) begin
        running_sum <= running_sum + pay_val;
        byte_count  <= sts.pay_done ? '0 : byte_count + 1'b1;
      end
    end else if (cmd.chk) begin
      sum_fault <= (rx_byte != ~running_sum);
    end
  end

  // big-endian word assembly
  always_ff @(posedge clk) begin
    if (cmd.pay && pay_take) begin
      word_shift <= {word_shift[15:0], pay_val};
    end
  end

  // payload word store
  always_ff @(posedge clk) begin
    if (word_wr) begin
      word_store[wr_addr] <= {word_shift, pay_val};
    end
    if (cmd.rd) begin
      rd_data <= word_store[widx];
    end
  end

  // stream word index
  always_ff @(posedge clk) begin
    if (rst) begin
      widx <= '0;
    end else if (cmd.wclr) begin
      widx <= '0;
    end else if (cmd.ld && !sts.word_last) begin
      widx <= widx + 1'b1;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.ld || cmd.emit_st) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.ld) begin
      word_value   <= rd_data;
      word_index   <= IDX_W'(widx);
      frame_status <= ST_OK;
      last         <= sts.word_last;
    end else if (cmd.emit_st) begin
      word_value   <= '0;
      word_index   <= '0;
      frame_status <= cmd.st_code;
      last         <= 1'b1;
    end
  end

endmodule

>>> rtl/core/bsfd_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bsfd_ctrl
// Frame phase state machine; drives datapath commands and input ready.
// ----------------------------------------------------------------------------
module bsfd_ctrl import bsfd_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_ready,
  input  dec_sts_t sts,
  output dec_cmd_t cmd
);

  localparam logic [2:0] S_HUNT    = 3'd0;
  localparam logic [2:0] S_HEADER  = 3'd1;
  localparam logic [2:0] S_PAYLOAD = 3'd2;
  localparam logic [2:0] S_CHECK   = 3'd3;
  localparam logic [2:0] S_END     = 3'd4;
  localparam logic [2:0] S_RD      = 3'd5;
  localparam logic [2:0] S_LD      = 3'd6;

  logic [2:0] state;
  logic [2:0] state_next;
  logic       byte_phase;
  logic       accept;

  // bytes are taken only in the receive phases and while the output can move
  always_comb begin
    byte_phase = (state != S_RD) && (state != S_LD);
    in_ready   = byte_phase && sts.out_free;
    accept     = in_valid && in_ready;
  end

  // next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      S_HEADER: begin
        if (accept) begin
          cmd.hdr = 1'b1;
          if (sts.hdr_done) begin
            if (sts.hdr_fault) begin
              cmd.emit_st = 1'b1;
              cmd.st_code = ST_DEV_STATE;
              state_next  = S_HUNT;
            end else begin
              state_next = S_PAYLOAD;
            end
          end
        end
      end
      S_PAYLOAD: begin
        if (accept) begin
          cmd.pay = 1'b1;
          if (sts.pay_done) begin
            state_next = S_CHECK;
          end
        end
      end
      S_CHECK: begin
        if (accept) begin
          cmd.chk    = 1'b1;
          state_next = S_END;
        end
      end
      S_END: begin
        if (accept) begin
          if (!sts.is_flag) begin
            cmd.emit_st = 1'b1;
            cmd.st_code = ST_BAD_END;
            state_next  = S_HUNT;
          end else if (sts.sum_fault) begin
            cmd.emit_st = 1'b1;
            cmd.st_code = ST_BAD_SUM;
            state_next  = S_HUNT;
          end else begin
            cmd.wclr   = 1'b1;
            state_next = S_RD;
          end
        end
      end
      S_RD: begin
        cmd.rd     = 1'b1;
        state_next = S_LD;
      end
      S_LD: begin
        if (sts.out_free) begin
          cmd.ld     = 1'b1;
          state_next = sts.word_last ? S_HUNT : S_RD;
        end
      end
      default: begin
        // hunting, and unused codes behave the same
        state_next = S_HUNT;
        if (accept && sts.is_flag) begin
          cmd.start  = 1'b1;
          state_next = S_HEADER;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_HUNT;
    end else begin
      state <= state_next;
    end
  end

endmodule

>>> rtl/core/byte_stuffed_frame_decoder_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// byte_stuffed_frame_decoder_core
// Byte-stuffed sensor frame decoder: hunts for the start flag, checks header,
// unstuffs and sums the payload, verifies checksum and end flag, then streams
// the payload as big-endian 32-bit words or reports one failure status.
// ----------------------------------------------------------------------------
// Usage
//   Input channel in_valid / in_ready / rx_byte carries one received byte per
//   transaction. Output channel out_valid / out_ready carries word_value,
//   word_index, frame_status and last, one result per transaction.
//   While receiving and while the output can move, one byte is taken per
//   cycle; a byte that ends a failed frame gives its status result in the
//   cycle after acceptance. After a good end flag the PAYLOAD_BYTES/4 words
//   are read from the word store one by one, each by a store read and then
//   an output load; in_ready is low until the last word is loaded.
//   A stalled receiver holds the result in the output register; a new byte
//   is taken only while that register is empty or being drained.
//   Reset clears the output and returns to hunting for the start flag.
// ----------------------------------------------------------------------------
module byte_stuffed_frame_decoder_core import bsfd_pkg::*; #(
  parameter int PAYLOAD_BYTES = PAYLOAD_BYTES_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [BYTE_W-1:0] rx_byte,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [WORD_W-1:0] word_value,
  output logic [IDX_W-1:0]  word_index,
  output logic [STAT_W-1:0] frame_status,
  output logic              last
);

  localparam int NUM_WORDS = PAYLOAD_BYTES / 4;

  dec_cmd_t cmd;
  dec_sts_t sts;

  // phase controller
  bsfd_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // datapath and output register
  bsfd_datapath #(
    .PAYLOAD_BYTES (PAYLOAD_BYTES)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .rx_byte      (rx_byte),
    .cmd          (cmd),
    .sts          (sts),
    .out_ready    (out_ready),
    .out_valid    (out_valid),
    .word_value   (word_value),
    .word_index   (word_index),
    .frame_status (frame_status),
    .last         (last)
  );

`ifndef SYNTHESIS
  // a byte is only taken when the output register can move
  a_ready_out_free: assert property (@(posedge clk) disable iff (rst)
    in_ready |-> (!out_valid || out_ready))
    else $error("byte taken while output register is stalled");

  // failure status is a single zero result marked last
  a_status_form: assert property (@(posedge clk) disable iff (rst)
    (out_valid && frame_status != ST_OK) |->
      (last && word_value == '0 && word_index == '0))
    else $error("malformed status result");

  // the final word of a good frame carries the top index
  a_last_word: assert property (@(posedge clk) disable iff (rst)
    (out_valid && frame_status == ST_OK && last) |->
      (word_index == IDX_W'(NUM_WORDS - 1)))
    else $error("last flag on wrong word");

  // output empty right after reset
  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> !out_valid)
    else $error("output valid after reset");
`endif

endmodule

>>> tb/tb_byte_stuffed_frame_decoder_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_byte_stuffed_frame_decoder_core
// Self-checking bench for the byte-stuffed frame decoder. A short table of
// hand-picked bytes covers hunting, flags inside the header and device state
// faults. Random framed traffic follows, with stuffing, bad checksums, bad
// end flags and line noise. The table or a local decoder model gives each
// result, and each output transaction is checked in order, field by field.
// ----------------------------------------------------------------------------
module tb_byte_stuffed_frame_decoder_core;
  import bsfd_pkg::*;

  localparam int N_PAYLOAD    = PAYLOAD_BYTES_DEF;
  localparam int N_WORDS      = N_PAYLOAD / 4;
  localparam int TARGET_BYTES = 480;
  localparam int TAIL_CYCLES  = 40;

  // how a table row sets its expectation
  localparam logic [1:0] ROW_NONE    = 2'd0;
  localparam logic [1:0] ROW_PREDICT = 2'd1;
  localparam logic [1:0] ROW_STATUS  = 2'd2;

  // kinds of random traffic
  localparam int FK_GOOD      = 0;
  localparam int FK_BAD_SUM   = 1;
  localparam int FK_BAD_END   = 2;
  localparam int FK_BAD_BOTH  = 3;
  localparam int FK_DEV_STATE = 4;
  localparam int FK_NOISE     = 5;

  typedef enum logic [2:0] {
    PH_HUNT, PH_HEADER, PH_PAYLOAD, PH_CHECK, PH_TRAILER
  } frame_phase_e;

  typedef struct packed {
    logic [WORD_W-1:0] value;
    logic [IDX_W-1:0]  index;
    logic [STAT_W-1:0] status;
    logic              last;
  } frame_result_t;

  typedef struct packed {
    logic [BYTE_W-1:0] rx;
    logic [1:0]        how;
    logic [STAT_W-1:0] status;
  } dir_row_t;

  // hunting, flags as header bytes, state byte faults
  localparam int N_DIR = 20;
  localparam dir_row_t DIRECTED [N_DIR] = '{
    '{8'h00,     ROW_NONE,    ST_OK},
    '{8'hFF,     ROW_NONE,    ST_OK},
    '{ESC_BYTE,  ROW_NONE,    ST_OK},
    '{8'h5E,     ROW_NONE,    ST_OK},
    '{FLAG_BYTE, ROW_NONE,    ST_OK},
    '{8'hFF,     ROW_NONE,    ST_OK},
    '{8'h00,     ROW_NONE,    ST_OK},
    '{8'h01,     ROW_NONE,    ST_OK},
    '{8'h28,     ROW_STATUS,  ST_DEV_STATE},
    '{FLAG_BYTE, ROW_NONE,    ST_OK},
    '{FLAG_BYTE, ROW_NONE,    ST_OK},
    '{ESC_BYTE,  ROW_NONE,    ST_OK},
    '{8'hFF,     ROW_NONE,    ST_OK},
    '{FLAG_BYTE, ROW_STATUS,  ST_DEV_STATE},
    '{8'hA5,     ROW_NONE,    ST_OK},
    '{FLAG_BYTE, ROW_NONE,    ST_OK},
    '{8'h00,     ROW_PREDICT, ST_OK},
    '{8'h00,     ROW_PREDICT, ST_OK},
    '{8'h80,     ROW_PREDICT, ST_OK},
    '{8'h00,     ROW_STATUS,  ST_DEV_STATE}
  };

  logic              clk;
  logic              rst;
  logic              in_valid;
  logic              in_ready;
  logic [BYTE_W-1:0] rx_byte;
  logic              out_valid;
  logic              out_ready;
  logic [WORD_W-1:0] word_value;
  logic [IDX_W-1:0]  word_index;
  logic [STAT_W-1:0] frame_status;
  logic              last;

  // decoder model state
  frame_phase_e      dec_phase = PH_HUNT;
  logic [5:0]        dec_count = '0;
  logic [BYTE_W-1:0] dec_sum = '0;
  logic              dec_escape = 1'b0;
  logic              dec_state_bad = 1'b0;
  logic              dec_sum_bad = 1'b0;
  logic [BYTE_W-1:0] dec_store [N_PAYLOAD];

  frame_result_t step_results[$];
  frame_result_t pending_results[$];
  int taken_bytes = 0;
  int errors = 0;
  int send_idle_pct = 25;
  int recv_idle_pct = 63;

  byte_stuffed_frame_decoder_core u_top (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .rx_byte      (rx_byte),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .word_value   (word_value),
    .word_index   (word_index),
    .frame_status (frame_status),
    .last         (last)
  );

  // clock
  initial clk = 1'b0;
  always #6 clk = ~clk;

  function automatic frame_result_t status_result(input logic [STAT_W-1:0] code);
    frame_result_t r;
    r = '{'0, '0, code, 1'b1};
    return r;
  endfunction

  // store one unstuffed payload byte and fold it into the sum
  function automatic void store_payload(input logic [BYTE_W-1:0] v);
    dec_store[dec_count] = v;
    dec_sum = dec_sum + v;
    if (dec_count >= N_PAYLOAD - 1) begin
      dec_phase = PH_CHECK;
      dec_count = '0;
    end else begin
      dec_count = dec_count + 6'd1;
    end
  endfunction

  // advance the decoder model by one byte, results land in step_results
  function automatic void decode_byte(input logic [BYTE_W-1:0] b);
    logic [BYTE_W-1:0] v;
    logic [WORD_W-1:0] w;
    frame_result_t     r;
    step_results.delete();
    if (dec_phase != PH_HUNT || b == FLAG_BYTE) taken_bytes++;
    case (dec_phase)
      PH_HEADER: begin
        dec_sum = dec_sum + b;
        if (dec_count == 6'd2 && b != 8'h00) dec_state_bad = 1'b1;
        if (dec_count >= 6'd3) begin
          dec_count = '0;
          if (dec_state_bad) begin
            step_results.push_back(status_result(ST_DEV_STATE));
            dec_phase = PH_HUNT;
          end else begin
            dec_phase = PH_PAYLOAD;
          end
        end else begin
          dec_count = dec_count + 6'd1;
        end
      end
      PH_PAYLOAD: begin
        if (dec_escape) begin
          dec_escape = 1'b0;
          case (b)
            ESC_FLAG_CODE: v = FLAG_BYTE;
            ESC_ESC_CODE:  v = ESC_BYTE;
            ESC_XON_CODE:  v = XON_BYTE;
            ESC_XOFF_CODE: v = XOFF_BYTE;
            default:       v = ESC_BYTE;
          endcase
          store_payload(v);
        end else if (b == ESC_BYTE) begin
          dec_escape = 1'b1;
        end else begin
          store_payload(b);
        end
      end
      PH_CHECK: begin
        dec_sum_bad = (b != ~dec_sum);
        dec_phase = PH_TRAILER;
      end
      PH_TRAILER: begin
        if (b != FLAG_BYTE) begin
          step_results.push_back(status_result(ST_BAD_END));
        end else if (dec_sum_bad) begin
          step_results.push_back(status_result(ST_BAD_SUM));
        end else begin
          for (int k = 0; k < N_WORDS; k++) begin
            w = {dec_store[4*k], dec_store[4*k+1], dec_store[4*k+2], dec_store[4*k+3]};
            r = '{w, IDX_W'(k), ST_OK, (k == N_WORDS - 1)};
            step_results.push_back(r);
          end
        end
        dec_phase = PH_HUNT;
      end
      default: begin
        dec_phase = PH_HUNT;
        if (b == FLAG_BYTE) begin
          dec_phase = PH_HEADER;
          dec_count = '0;
          dec_sum = '0;
          dec_escape = 1'b0;
          dec_state_bad = 1'b0;
          dec_sum_bad = 1'b0;
        end
      end
    endcase
  endfunction

  // one input transaction, then queue what it should produce
  task automatic transmit_byte(input logic [BYTE_W-1:0] b,
                               input logic [1:0] how = ROW_PREDICT,
                               input logic [STAT_W-1:0] code = ST_OK);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    rx_byte  <= b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    decode_byte(b);
    case (how)
      ROW_PREDICT: foreach (step_results[i]) pending_results.push_back(step_results[i]);
      ROW_STATUS:  pending_results.push_back(status_result(code));
      default: ;
    endcase
  endtask

  // build and send one framed sequence with random content
  task automatic send_frame(input int kind);
    logic [BYTE_W-1:0] hdr [4];
    logic [BYTE_W-1:0] v;
    logic [BYTE_W-1:0] follower;
    logic [BYTE_W-1:0] total;
    logic [BYTE_W-1:0] tail;
    hdr[0] = 8'($urandom_range(255));
    hdr[1] = 8'($urandom_range(255));
    hdr[2] = (kind == FK_DEV_STATE) ? 8'($urandom_range(255, 1)) : 8'h00;
    hdr[3] = 8'($urandom_range(255));
    total = '0;
    transmit_byte(FLAG_BYTE);
    for (int i = 0; i < 4; i++) begin
      transmit_byte(hdr[i]);
      total = total + hdr[i];
    end
    if (kind == FK_DEV_STATE) return;

    // payload, leaning on the bytes that need stuffing
    for (int i = 0; i < N_PAYLOAD; i++) begin
      if ($urandom_range(3) == 0) begin
        case ($urandom_range(3))
          0:       v = FLAG_BYTE;
          1:       v = ESC_BYTE;
          2:       v = XON_BYTE;
          default: v = XOFF_BYTE;
        endcase
      end else begin
        v = 8'($urandom_range(255));
      end
      total = total + v;
      case (v)
        FLAG_BYTE: begin
          if ($urandom_range(9) < 7) begin
            transmit_byte(ESC_BYTE);
            transmit_byte(ESC_FLAG_CODE);
          end else begin
            transmit_byte(v);
          end
        end
        ESC_BYTE: begin
          transmit_byte(ESC_BYTE);
          if ($urandom_range(9) < 6) begin
            transmit_byte(ESC_ESC_CODE);
          end else begin
            // unknown follower still stands for the escape byte
            do follower = 8'($urandom_range(255));
            while (follower == ESC_FLAG_CODE || follower == ESC_ESC_CODE ||
                   follower == ESC_XON_CODE || follower == ESC_XOFF_CODE);
            transmit_byte(follower);
          end
        end
        XON_BYTE: begin
          if ($urandom_range(1) == 1) begin
            transmit_byte(ESC_BYTE);
            transmit_byte(ESC_XON_CODE);
          end else begin
            transmit_byte(v);
          end
        end
        XOFF_BYTE: begin
          if ($urandom_range(1) == 1) begin
            transmit_byte(ESC_BYTE);
            transmit_byte(ESC_XOFF_CODE);
          end else begin
            transmit_byte(v);
          end
        end
        default: transmit_byte(v);
      endcase
    end

    // checksum sent raw, then the end flag
    v = ~total;
    if (kind == FK_BAD_SUM || kind == FK_BAD_BOTH) v = v ^ 8'($urandom_range(255, 1));
    transmit_byte(v);
    tail = FLAG_BYTE;
    if (kind == FK_BAD_END || kind == FK_BAD_BOTH) tail = tail ^ 8'($urandom_range(255, 1));
    transmit_byte(tail);
  endtask

  // stimulus
  initial begin
    logic [BYTE_W-1:0] fill;
    int frame_no;
    int kind;
    int roll;
    rst      = 1'b1;
    in_valid = 1'b0;
    rx_byte  = '0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed table
    foreach (DIRECTED[i]) transmit_byte(DIRECTED[i].rx, DIRECTED[i].how, DIRECTED[i].status);

    // random frames, every kind once first
    frame_no = 0;
    while (taken_bytes < TARGET_BYTES) begin
      if (taken_bytes < TARGET_BYTES / 3) begin
        send_idle_pct = 25;
        recv_idle_pct = 63;
      end else if (taken_bytes < 2 * TARGET_BYTES / 3) begin
        send_idle_pct = 63;
        recv_idle_pct = 25;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      if (frame_no <= FK_NOISE) begin
        kind = frame_no;
      end else begin
        roll = $urandom_range(99);
        if (roll < 50)      kind = FK_GOOD;
        else if (roll < 60) kind = FK_BAD_SUM;
        else if (roll < 70) kind = FK_BAD_END;
        else if (roll < 78) kind = FK_BAD_BOTH;
        else if (roll < 90) kind = FK_DEV_STATE;
        else                kind = FK_NOISE;
      end
      if (kind == FK_NOISE) begin
        repeat ($urandom_range(6, 1)) transmit_byte(8'($urandom_range(255)));
      end else begin
        send_frame(kind);
      end
      // idle line filler between frames
      repeat ($urandom_range(2)) begin
        do fill = 8'($urandom_range(255));
        while (fill == FLAG_BYTE);
        transmit_byte(fill);
      end
      frame_no++;
    end

    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("tb_byte_stuffed_frame_decoder_core passed");
    end else begin
      $display("tb_byte_stuffed_frame_decoder_core failed");
    end
    $finish;
  end

  // receiver back-pressure
  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  function automatic void check_field(input string what, input logic [WORD_W-1:0] want,
                                      input logic [WORD_W-1:0] got);
    if (got !== want) begin
      $display("%0t: %s expected %h got %h", $time, what, want, got);
      errors++;
    end
  endfunction

  // compare each output transaction with the oldest expectation
  always @(posedge clk) begin : result_monitor
    frame_result_t want;
    if (!rst && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result expected none got value %h index %0d status %0d last %0d",
                 $time, word_value, word_index, frame_status, last);
        errors++;
      end else begin
        want = pending_results.pop_front();
        check_field("word_value", want.value, word_value);
        check_field("word_index", WORD_W'(want.index), WORD_W'(word_index));
        check_field("frame_status", WORD_W'(want.status), WORD_W'(frame_status));
        check_field("last", WORD_W'(want.last), WORD_W'(last));
      end
    end
  end

  // run limit
  initial begin
    #2000000;
    $display("tb_byte_stuffed_frame_decoder_core failed");
    $finish;
  end

endmodule
